// ===== hw/rtl/tsps_pkg.sv =====
// Package for the thermostat schedule period select block.
// Holds schedule geometry constants, command codes and the memory port types.
// No dependencies.
package tsps_pkg;

   localparam int SCHED_BYTES  = 54;
   localparam int GROUP_BYTES  = 18;
   localparam int PERIOD_BYTES = 3;
   localparam int PERIODS      = 6;
   localparam int ADDR_W       = 6;
   localparam int DATA_W       = 8;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] byte_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      byte_type data;
   } mem_wr_type;

   typedef struct packed {
      addr_type addr_a;
      addr_type addr_b;
   } mem_rd_type;

endpackage

// ===== hw/rtl/tsps_sched_mem.sv =====
// Schedule byte store: one write port and two synchronous read ports.
// Entries never written since reset read as zero through per-entry valid bits.
// Depends on tsps_pkg.
module tsps_sched_mem (
   input  logic                clock,
   input  logic                reset,
   input  tsps_pkg::mem_wr_type wr,
   input  tsps_pkg::mem_rd_type rd,
   output tsps_pkg::byte_type  rd_a_data,
   output tsps_pkg::byte_type  rd_b_data
);
   import tsps_pkg::*;

   byte_type                 sched_mem_ff [SCHED_BYTES];
   logic [SCHED_BYTES-1:0]   valid_ff;
   byte_type                 q_a_ff;
   byte_type                 q_b_ff;
   logic                     ok_a_ff;
   logic                     ok_b_ff;
   logic                     wr_ok;
   logic                     in_a;
   logic                     in_b;

   assign wr_ok = wr.en && (wr.addr < ADDR_W'(SCHED_BYTES));
   assign in_a  = rd.addr_a < ADDR_W'(SCHED_BYTES);
   assign in_b  = rd.addr_b < ADDR_W'(SCHED_BYTES);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         sched_mem_ff[wr.addr] <= wr.data;
      end
      if (in_a) begin
         q_a_ff <= sched_mem_ff[rd.addr_a];
      end
      if (in_b) begin
         q_b_ff <= sched_mem_ff[rd.addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ok_a_ff  <= 1'b0;
         ok_b_ff  <= 1'b0;
      end else begin
         if (wr_ok) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         ok_a_ff <= in_a && valid_ff[rd.addr_a];
         ok_b_ff <= in_b && valid_ff[rd.addr_b];
      end
   end

   assign rd_a_data = ok_a_ff ? q_a_ff : '0;
   assign rd_b_data = ok_b_ff ? q_b_ff : '0;

endmodule

// ===== hw/rtl/thermostat_schedule_period_select_core.sv =====
// Thermostat schedule period select: top level with the scan sequencer.
// Uses tsps_pkg and tsps_sched_mem.
//
// A write transfer leaves busy low, so the next transfer may follow at once.
// An evaluate transfer's result is given after a scan of up to six periods through the
// schedule memory (one period per cycle, registered reads), then a read of the setpoint
// byte; a scan that breaks at period 0 is the shortest.
// Busy stays high through the strobe cycle, so after an evaluate the next transfer is
// accepted only once the result has been given.
// An evaluate transfer with time_valid low finishes in the cycle it is accepted, no result.
// Synchronous reset clears the schedule (all bytes read as zero), time_valid and the
// last-evaluation record; the receiver cannot stall, so each result lasts exactly one cycle.
module thermostat_schedule_period_select_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_cmd,
   input  logic [5:0] req_byte_index,
   input  logic [7:0] req_byte_value,
   input  logic [2:0] req_weekday,
   input  logic [4:0] req_hour_now,
   input  logic [5:0] req_minute_now,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output logic       rsp_valid,
   output logic [2:0] rsp_active_day,
   output logic [2:0] rsp_active_period,
   output logic [7:0] rsp_period_setpoint,
   output logic       rsp_period_changed
);
   import tsps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OUT
   } state_type;

   // Byte offset of a day group: weekdays use group 0, Saturday group 1, Sunday group 2.
   function automatic addr_type group_base(input logic [2:0] day);
      addr_type b;
      if (day <= 3'd4) begin
         b = '0;
      end else if (day == 3'd5) begin
         b = ADDR_W'(GROUP_BYTES);
      end else begin
         b = ADDR_W'(2 * GROUP_BYTES);
      end
      return b;
   endfunction

   function automatic addr_type period_off(input logic [2:0] p);
      return ADDR_W'(p) * ADDR_W'(PERIOD_BYTES);
   endfunction

   state_type  state_ff, state_in;
   logic       time_valid_ff;
   logic [2:0] day_ff, day_in;
   logic [4:0] hour_ff, hour_in;
   logic [5:0] minute_ff, minute_in;
   addr_type   base_ff, base_in;
   logic [2:0] issue_ff, issue_in;     // next period whose bytes get read
   logic       pend_ff, pend_in;       // memory output holds the bytes of period pidx_ff
   logic [2:0] pidx_ff, pidx_in;
   logic       found_ff, found_in;
   logic [2:0] per_ff, per_in;
   logic [2:0] last_day_ff, last_day_in;
   logic [2:0] last_per_ff, last_per_in;
   logic [2:0] out_day_ff, out_day_in;
   logic [2:0] out_per_ff, out_per_in;
   logic       changed_ff, changed_in;

   mem_wr_type mem_wr;
   mem_rd_type mem_rd;
   byte_type   minute_byte;
   byte_type   hour_byte;

   logic       accept;
   logic       brk;
   logic       stop;
   logic       found_now;
   logic [2:0] per_now;
   logic [2:0] fin_day;
   logic [2:0] fin_per;
   logic [2:0] day_remap;

   tsps_sched_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .wr        (mem_wr),
      .rd        (mem_rd),
      .rd_a_data (minute_byte),
      .rd_b_data (hour_byte)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Write transfers go straight to the memory; out-of-range indexes are dropped there.
   assign mem_wr.en   = accept && (req_cmd == CMD_WRITE);
   assign mem_wr.addr = req_byte_index;
   assign mem_wr.data = req_byte_value;

   // Sunday is 0 on the request side and 6 after the remap; weekday seven behaves as Sunday.
   assign day_remap = (req_weekday == 3'd0) ? 3'd6 : 3'(req_weekday - 3'd1);

   // A period breaks the scan when its start lies after the current time.
   assign brk = pend_ff &&
                ((byte_type'(hour_ff) < hour_byte) ||
                 ((byte_type'(hour_ff) == hour_byte) && (byte_type'(minute_ff) < minute_byte)));
   assign found_now = found_ff || (pend_ff && !brk);
   assign per_now   = (pend_ff && !brk) ? pidx_ff : per_ff;
   assign stop      = (state_ff == ST_SCAN) &&
                      (brk || (pend_ff && (pidx_ff == 3'(PERIODS - 1))));

   // Nothing started today: the last period of the previous day is still running.
   always_comb begin
      if (found_now) begin
         fin_day = day_ff;
         fin_per = per_now;
      end else begin
         fin_day = (day_ff == 3'd0) ? 3'd6 : 3'(day_ff - 3'd1);
         fin_per = 3'(PERIODS - 1);
      end
   end

   // Port A reads the minute byte during the scan and the setpoint byte once it ends;
   // port B reads the hour byte.
   always_comb begin
      if (stop) begin
         mem_rd.addr_a = group_base(fin_day) + period_off(fin_per) + ADDR_W'(2);
      end else begin
         mem_rd.addr_a = base_ff + period_off(issue_ff);
      end
      mem_rd.addr_b = base_ff + period_off(issue_ff) + ADDR_W'(1);
   end

   always_comb begin
      state_in    = state_ff;
      day_in      = day_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      base_in     = base_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      found_in    = found_ff;
      per_in      = per_ff;
      last_day_in = last_day_ff;
      last_per_in = last_per_ff;
      out_day_in  = out_day_ff;
      out_per_in  = out_per_ff;
      changed_in  = changed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_EVAL) && time_valid_ff) begin
               state_in  = ST_SCAN;
               day_in    = day_remap;
               hour_in   = req_hour_now;
               minute_in = req_minute_now;
               base_in   = group_base(day_remap);
               issue_in  = '0;
               found_in  = 1'b0;
               per_in    = '0;
            end
         end
         ST_SCAN: begin
            found_in = found_now;
            per_in   = per_now;
            if (stop) begin
               state_in    = ST_OUT;
               out_day_in  = fin_day;
               out_per_in  = fin_per;
               changed_in  = (fin_day != last_day_ff) || (fin_per != last_per_ff);
               last_day_in = fin_day;
               last_per_in = fin_per;
            end else if (issue_ff < 3'(PERIODS)) begin
               pend_in  = 1'b1;
               pidx_in  = issue_ff;
               issue_in = 3'(issue_ff + 3'd1);
            end
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state is reset; the scan datapath and result registers are loaded before use.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_valid_ff <= 1'b0;
         pend_ff       <= 1'b0;
         last_day_ff   <= 3'd7;
         last_per_ff   <= 3'd7;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         last_day_ff <= last_day_in;
         last_per_ff <= last_per_in;
         if (csr_wr_en) begin
            time_valid_ff <= csr_wr_data;
         end
      end
      day_ff     <= day_in;
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      base_ff    <= base_in;
      issue_ff   <= issue_in;
      pidx_ff    <= pidx_in;
      found_ff   <= found_in;
      per_ff     <= per_in;
      out_day_ff <= out_day_in;
      out_per_ff <= out_per_in;
      changed_ff <= changed_in;
   end

   // The setpoint byte arrives from the memory in the cycle of the result strobe.
   assign rsp_valid           = (state_ff == ST_OUT);
   assign rsp_active_day      = out_day_ff;
   assign rsp_active_period   = out_per_ff;
   assign rsp_period_setpoint = minute_byte;
   assign rsp_period_changed  = changed_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for thermostat_schedule_period_select_core.
// It predicts each period-select result from its own schedule model and checks the result port.
// Depends on tsps_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
   import tsps_pkg::*;

   // Bound on the wait from an evaluate transfer's acceptance to its result strobe.
   localparam int EVAL_LATENCY   = 8;
   localparam int SETTLE_CYCLES  = EVAL_LATENCY + 4;
   localparam int USEFUL_TARGET  = 1500;
   // The limit covers the slowest correct run: the gap, scan and strobe of each of a few
   // thousand transfers, plus the settle time around each register write.
   localparam int CYCLE_LIMIT    = 600000;
   localparam logic [2:0] NO_DAY    = 3'd7;
   localparam logic [2:0] NO_PERIOD = 3'd7;

   // One command transfer as it appears on the req_ ports.
   typedef struct packed {
      logic       cmd;
      addr_type   index;
      byte_type   value;
      logic [2:0] weekday;
      logic [4:0] hour;
      logic [5:0] minute;
   } sched_req_type;

   // One result transfer as it appears on the rsp_ ports.
   typedef struct packed {
      logic [2:0] day;
      logic [2:0] period;
      byte_type   setpoint;
      logic       changed;
   } period_result_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_cmd = CMD_WRITE;
   logic [5:0] req_byte_index = '0;
   logic [7:0] req_byte_value = '0;
   logic [2:0] req_weekday = '0;
   logic [4:0] req_hour_now = '0;
   logic [5:0] req_minute_now = '0;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       rsp_valid;
   logic [2:0] rsp_active_day;
   logic [2:0] rsp_active_period;
   logic [7:0] rsp_period_setpoint;
   logic       rsp_period_changed;

   thermostat_schedule_period_select_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_byte_index      (req_byte_index),
      .req_byte_value      (req_byte_value),
      .req_weekday         (req_weekday),
      .req_hour_now        (req_hour_now),
      .req_minute_now      (req_minute_now),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_active_day      (rsp_active_day),
      .rsp_active_period   (rsp_active_period),
      .rsp_period_setpoint (rsp_period_setpoint),
      .rsp_period_changed  (rsp_period_changed)
   );

   // Pending command transfers, filled by the stimulus process and drained by the driver.
   sched_req_type     pending_reqs[$];
   // Period selections that the block still owes, oldest first.
   period_result_type expected_periods[$];

   // Predictor state: the schedule as the block should hold it, the last selection and
   // the time_valid register.
   byte_type   sched_copy[SCHED_BYTES];
   logic [2:0] prior_day;
   logic [2:0] prior_period;
   logic       time_known;

   // The stimulus side keeps its own view of the schedule so that it can aim evaluation
   // times at period boundaries; it runs ahead of the block, so it cannot share sched_copy.
   byte_type   plan_mem[SCHED_BYTES];
   logic       plan_valid = 1'b0;
   int         useful_count = 0;
   int         reqs_in_flight = 0;

   int         error_count = 0;
   int         cycle_count = 0;
   logic       took_item = 1'b0;
   int         burst_left = 1;
   int         gap_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   // Monday-based day from the Sunday-based weekday; weekday seven falls on Sunday too.
   function automatic logic [2:0] monday_day(input logic [2:0] wd);
      return (wd == 3'd0 || wd == 3'd7) ? 3'd6 : wd - 3'd1;
   endfunction

   // First schedule byte of the day group that serves a Monday-based day.
   function automatic int group_base(input logic [2:0] day);
      int grp;
      grp = (day > 3'd4) ? int'(day) - 4 : 0;
      if (grp > 2)
         grp = 2;
      return grp * GROUP_BYTES;
   endfunction

   // Applies one accepted transfer to the predictor. Returns 1 and the expected selection
   // when the transfer is an evaluation that produces a result.
   function automatic bit predict_selection(input sched_req_type r,
                                            output period_result_type res);
      logic [2:0] day;
      logic [2:0] per;
      bit         found;
      bit         stop;
      int         base;
      byte_type   st_min;
      byte_type   st_hour;
      res = '0;
      if (r.cmd == CMD_WRITE) begin
         if (r.index < SCHED_BYTES)
            sched_copy[r.index] = r.value;
         return 1'b0;
      end
      if (!time_known)
         return 1'b0;
      day   = monday_day(r.weekday);
      base  = group_base(day);
      per   = 3'd0;
      found = 1'b0;
      stop  = 1'b0;
      // The active period is the last one in sequence whose start is not after now;
      // the scan ends at the first period that has not started yet.
      for (int p = 0; p < PERIODS; p++) begin
         st_min  = sched_copy[base + p * PERIOD_BYTES];
         st_hour = sched_copy[base + p * PERIOD_BYTES + 1];
         if (!stop) begin
            if ({3'b000, r.hour} < st_hour ||
                ({3'b000, r.hour} == st_hour && {2'b00, r.minute} < st_min)) begin
               stop = 1'b1;
            end else begin
               per   = 3'(p);
               found = 1'b1;
            end
         end
      end
      // Before the first period of the day the last period of the previous day still rules.
      if (!found) begin
         day = (day == 3'd0) ? 3'd6 : day - 3'd1;
         per = 3'(PERIODS - 1);
      end
      res.day      = day;
      res.period   = per;
      res.setpoint = sched_copy[group_base(day) + int'(per) * PERIOD_BYTES + 2];
      res.changed  = (day != prior_day || per != prior_period);
      prior_day    = day;
      prior_period = per;
      return 1'b1;
   endfunction

   // Monitor and predictor. Everything is sampled at the rising edge, where the block's
   // outputs and the driven inputs both still hold their values from the cycle that ends.
   always @(posedge clock) begin : monitor
      period_result_type want;
      period_result_type got;
      sched_req_type     seen;
      if (reset) begin
         foreach (sched_copy[i])
            sched_copy[i] = '0;
         prior_day    = NO_DAY;
         prior_period = NO_PERIOD;
         time_known   = 1'b0;
         took_item   <= 1'b0;
      end else begin
         took_item <= start && !busy;
         // A strobe belongs to a transfer accepted earlier, so it is checked before this
         // edge's transfer is predicted.
         if (rsp_valid) begin
            got = '{rsp_active_day, rsp_active_period, rsp_period_setpoint,
                    rsp_period_changed};
            if (expected_periods.size() == 0) begin
               report_mismatch($sformatf("result day %0d period %0d with nothing pending",
                                         got.day, got.period));
            end else begin
               want = expected_periods.pop_front();
               if (got.day !== want.day)
                  report_mismatch($sformatf("active_day %0d, expected %0d",
                                            got.day, want.day));
               if (got.period !== want.period)
                  report_mismatch($sformatf("active_period %0d, expected %0d",
                                            got.period, want.period));
               if (got.setpoint !== want.setpoint)
                  report_mismatch($sformatf("period_setpoint %0d, expected %0d",
                                            got.setpoint, want.setpoint));
               if (got.changed !== want.changed)
                  report_mismatch($sformatf("period_changed %0b, expected %0b",
                                            got.changed, want.changed));
            end
         end
         if (csr_wr_en)
            time_known = csr_wr_data;
         if (start && !busy) begin
            seen = '{req_cmd, req_byte_index, req_byte_value, req_weekday,
                     req_hour_now, req_minute_now};
            reqs_in_flight--;
            if (predict_selection(seen, want))
               expected_periods.push_back(want);
         end
      end
   end

   // Driver. It changes the inputs at the falling edge only. It moves on after a transfer
   // or while start is low, and sends in bursts with random gaps between them.
   always @(negedge clock) begin : driver
      sched_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            start <= 1'b0;
         end else begin
            nxt = pending_reqs.pop_front();
            req_cmd        <= nxt.cmd;
            req_byte_index <= nxt.index;
            req_byte_value <= nxt.value;
            req_weekday    <= nxt.weekday;
            req_hour_now   <= nxt.hour;
            req_minute_now <= nxt.minute;
            start          <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               // Long bursts give stretches with no idling at all.
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_write(input int idx, input int val);
      sched_req_type r;
      r         = sched_req_type'({$urandom, $urandom});
      r.cmd     = CMD_WRITE;
      r.index   = addr_type'(idx);
      r.value   = byte_type'(val);
      if (idx < SCHED_BYTES) begin
         plan_mem[idx] = byte_type'(val);
         useful_count++;
      end
      reqs_in_flight++;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_eval(input int wd, input int hr, input int mn);
      sched_req_type r;
      r         = sched_req_type'({$urandom, $urandom});
      r.cmd     = CMD_EVAL;
      r.weekday = 3'(wd);
      r.hour    = 5'(hr);
      r.minute  = 6'(mn);
      if (plan_valid)
         useful_count++;
      reqs_in_flight++;
      pending_reqs.push_back(r);
   endtask

   // Waits until every transfer is taken and every result has come, then lets the block
   // settle before anything touches the register.
   task automatic wait_until_idle();
      while (reqs_in_flight != 0 || busy || expected_periods.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_time_valid(input logic v);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      plan_valid   = v;
   endtask

   // Programs one day group with six periods in start order, a few of them sharing a start.
   task automatic program_group(input int grp);
      int t;
      t = $urandom_range(0, 120);
      for (int p = 0; p < PERIODS; p++) begin
         queue_write(grp * GROUP_BYTES + p * PERIOD_BYTES,     t % 60);
         queue_write(grp * GROUP_BYTES + p * PERIOD_BYTES + 1, t / 60);
         queue_write(grp * GROUP_BYTES + p * PERIOD_BYTES + 2, $urandom_range(0, 255));
         t += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 300);
         if (t > 1439)
            t = 1439;
      end
   endtask

   // Picks an evaluation time: in half the cases at or next to a stored period start, else
   // anywhere in the day or sometimes beyond the legal hour and minute ranges.
   task automatic queue_random_eval();
      int wd;
      int base;
      int p;
      int hr;
      int mn;
      wd   = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, 6);
      base = group_base(monday_day(3'(wd)));
      case ($urandom_range(0, 3))
         0, 1: begin
            p  = $urandom_range(0, PERIODS - 1);
            hr = (plan_mem[base + p * PERIOD_BYTES + 1] < 32) ?
                 int'(plan_mem[base + p * PERIOD_BYTES + 1]) : $urandom_range(0, 23);
            mn = int'(plan_mem[base + p * PERIOD_BYTES]) + $urandom_range(0, 2) - 1;
         end
         2: begin
            hr = $urandom_range(0, 23);
            mn = $urandom_range(0, 59);
         end
         default: begin
            hr = $urandom_range(0, 31);
            mn = $urandom_range(0, 63);
         end
      endcase
      queue_eval(wd, hr, mn);
   endtask

   // Stimulus: reset, a short directed part, then random phases.
   initial begin : stimulus
      int n_evals;
      foreach (plan_mem[i])
         plan_mem[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With time_valid still at its reset value an evaluation gives nothing.
      queue_eval(3, 12, 0);
      set_time_valid(1'b1);
      // Cleared schedule: every period starts at midnight, so period 5 is active.
      // The first evaluation always reports a change; the repeat reports none.
      queue_eval(0, 0, 0);
      queue_eval(0, 0, 0);
      queue_write(1, 6);
      queue_write(0, 30);
      queue_write(4, 255);
      queue_write(2, 8'h55);
      queue_write(53, 255);
      // Indexes beyond the schedule are dropped.
      queue_write(54, 8'h11);
      queue_write(63, 8'hEE);
      // One minute before Monday's first period: Sunday's last period is still active.
      queue_eval(1, 6, 29);
      // Exactly at the start of the period, then a minute past it.
      queue_eval(1, 6, 30);
      queue_eval(2, 6, 31);
      // Tuesday before its first period falls back to Monday's last period.
      queue_eval(2, 0, 0);
      // Saturday, out-of-range hour and minute.
      queue_eval(6, 31, 63);
      // Weekday seven behaves as Sunday.
      queue_eval(7, 12, 0);
      queue_eval(0, 5, 59);
      set_time_valid(1'b0);
      queue_eval(0, 5, 59);
      set_time_valid(1'b1);
      // The ignored evaluation left the last selection alone: no change is reported.
      queue_eval(0, 5, 59);
      queue_write(0, 0);
      queue_eval(1, 0, 0);

      useful_count = 0;
      while (useful_count < USEFUL_TARGET) begin
         set_time_valid(($urandom_range(0, 4) != 0) ? 1'b1 : 1'b0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               for (int g = 0; g < 3; g++)
                  if ($urandom_range(0, 2) != 0)
                     program_group(g);
            end
            6, 7: begin
               repeat ($urandom_range(4, 16))
                  queue_write($urandom_range(0, 63), $urandom_range(0, 255));
            end
            default: ;
         endcase
         n_evals = $urandom_range(10, 40);
         repeat (n_evals) begin
            if ($urandom_range(0, 7) == 0)
               queue_write($urandom_range(0, 63), $urandom_range(0, 255));
            else
               queue_random_eval();
         end
      end

      wait_until_idle();
      if (expected_periods.size() != 0)
         report_mismatch($sformatf("%0d expected results never came",
                                   expected_periods.size()));
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
